// ===== hw/rtl/dba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dba_pkg: shared types and constants for the block allocator
// command codes, result codes, controller states and the control/status
// structs between controller and datapath
// ----------------------------------------------------------------------------
package dba_pkg;

    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned BYTES_W     = 12;
    localparam int unsigned NEED_W      = SIZE_W + 1;
    localparam int unsigned DIV_CNT_W   = 4;
    localparam int unsigned MAX_RESULTS = 32;

    localparam logic [BYTES_W-1:0]   BLOCK_BYTES_RESET = 12'd50;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST          = 4'd15;
    localparam logic [5:0]           COUNT_SAT         = 6'd63;

    typedef enum logic [1:0] {
        CMD_CONTIG  = 2'd0,
        CMD_INDEXED = 2'd1,
        CMD_MARK    = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        RS_ALLOC  = 2'd0,
        RS_NOFIT  = 2'd1,
        RS_MARKED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_MARK,
        RES_ZERO,
        RES_FAIL,
        RES_RUN,
        RES_TAKE
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_CHECK,
        S_MARK,
        S_RUN,
        S_FILL,
        S_COUNT,
        S_ENOUGH,
        S_TAKE
    } state_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      calc;
        logic      scan_init;
        logic      scan_step;
        logic      run_step;
        logic      cnt_step;
        res_kind_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic indexed;
        logic div_done;
        logic need_zero;
        logic need_over;
        logic scan_last;
        logic run_hit;
        logic cur_used;
        logic enough;
        logic take_done;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dba_ctrl: allocator sequencer
// steps the datapath through divide, range check, bitmap scans and results
// ----------------------------------------------------------------------------
module dba_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        command,
    input  wire dba_pkg::dp_stat_t stat,
    output      dba_pkg::dp_cmd_t  cmd,
    output      logic              busy
);
    import dba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command inside {CMD_CONTIG, CMD_INDEXED})
                    begin
                        state_next = S_DIV;
                    end
                    else if (command == CMD_MARK)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.need_zero || stat.need_over)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.indexed)
                begin
                    state_next = S_COUNT;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_MARK:
            begin
                state_next = S_IDLE;
            end
            S_RUN:
            begin
                if (stat.run_hit)
                begin
                    state_next = S_FILL;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                state_next = S_IDLE;
            end
            S_COUNT:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_ENOUGH;
                end
            end
            S_ENOUGH:
            begin
                state_next = stat.enough ? S_TAKE : S_IDLE;
            end
            S_TAKE:
            begin
                if (stat.take_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        cmd.emit = RES_NONE;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
            end
            S_CHECK:
            begin
                cmd.scan_init = 1'b1;
                if (stat.need_zero)
                begin
                    cmd.emit = RES_ZERO;
                end
                else if (stat.need_over)
                begin
                    cmd.emit = RES_FAIL;
                end
            end
            S_MARK:
            begin
                cmd.emit = RES_MARK;
            end
            S_RUN:
            begin
                cmd.scan_step = 1'b1;
                cmd.run_step  = 1'b1;
                if (!stat.run_hit && stat.scan_last)
                begin
                    cmd.emit = RES_FAIL;
                end
            end
            S_FILL:
            begin
                cmd.emit = RES_RUN;
            end
            S_COUNT:
            begin
                cmd.scan_step = 1'b1;
                cmd.cnt_step  = 1'b1;
            end
            S_ENOUGH:
            begin
                // second pass starts from block 0
                cmd.scan_init = 1'b1;
                if (!stat.enough)
                begin
                    cmd.emit = RES_FAIL;
                end
            end
            S_TAKE:
            begin
                cmd.scan_step = 1'b1;
                if (!stat.cur_used)
                begin
                    cmd.emit = RES_TAKE;
                end
            end
            default:
            begin
                cmd.emit = RES_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dba_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dba_datapath: bitmap, block-size register, divider and scan counters
// restoring divider one quotient bit per cycle, bitmap scanned one block per cycle
// ----------------------------------------------------------------------------
module dba_datapath #(
    parameter int BLOCK_TOTAL = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [dba_pkg::BYTES_W-1:0]     cfg_wdata,
    input  wire logic [1:0]                      command,
    input  wire logic [dba_pkg::SIZE_W-1:0]      file_size,
    input  wire logic [4:0]                      block_index,
    input  wire dba_pkg::dp_cmd_t                cmd,
    output      dba_pkg::dp_stat_t               stat,
    output      logic                            result_strobe,
    output      logic [1:0]                      status,
    output      logic [4:0]                      block_number,
    output      logic [4:0]                      entry_index,
    output      logic [5:0]                      block_count,
    output      logic                            last
);
    import dba_pkg::*;

    localparam int IW = $clog2(BLOCK_TOTAL);
    localparam int CW = $clog2(BLOCK_TOTAL + 1);

    logic [BYTES_W-1:0]     block_bytes_reg;
    logic [BLOCK_TOTAL-1:0] map_reg;
    logic [BLOCK_TOTAL-1:0] map_next;
    logic                   indexed_reg;
    logic                   size_zero_reg;
    logic [4:0]             idx_reg;
    logic [SIZE_W-1:0]      quot_reg;
    logic [BYTES_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [NEED_W-1:0]      need_reg;
    logic [IW-1:0]          scan_reg;
    logic [CW-1:0]          run_reg;
    logic [IW-1:0]          start_reg;
    logic [CW-1:0]          free_cnt_reg;
    logic [CW-1:0]          k_reg;

    logic                   strobe_reg;
    logic [1:0]             status_reg;
    logic [4:0]             number_reg;
    logic [4:0]             entry_reg;
    logic [5:0]             count_reg;
    logic                   last_reg;

    logic [BYTES_W:0]       trial;
    logic                   trial_ge;
    logic                   cur_used;
    logic [CW-1:0]          run_inc;
    logic [CW-1:0]          k_inc;
    logic                   idx_ok;
    logic [5:0]             count_sat;
    logic [BLOCK_TOTAL-1:0] run_mask;
    logic [1:0]             res_status;
    logic [4:0]             res_number;
    logic [4:0]             res_entry;
    logic [5:0]             res_count;
    logic                   res_last;

    // divider step: shift in next dividend bit, subtract when it fits
    assign trial    = {rem_reg, quot_reg[SIZE_W-1]};
    assign trial_ge = (trial >= {1'b0, block_bytes_reg});

    assign cur_used  = map_reg[scan_reg];
    assign run_inc   = run_reg + 1'b1;
    assign k_inc     = k_reg + 1'b1;
    assign idx_ok    = ({27'd0, idx_reg} < BLOCK_TOTAL);
    assign count_sat = (need_reg > NEED_W'(COUNT_SAT)) ? COUNT_SAT : need_reg[5:0];
    assign run_mask  = (~({BLOCK_TOTAL{1'b1}} << need_reg)) << start_reg;

    always_comb
    begin
        stat.indexed   = indexed_reg;
        stat.div_done  = (div_cnt_reg == DIV_LAST);
        stat.need_zero = (need_reg == '0);
        stat.need_over = (need_reg > NEED_W'(BLOCK_TOTAL))
                      || (need_reg > NEED_W'(MAX_RESULTS));
        stat.scan_last = (scan_reg == IW'(BLOCK_TOTAL - 1));
        stat.run_hit   = !cur_used && (NEED_W'(run_inc) == need_reg);
        stat.cur_used  = cur_used;
        stat.enough    = (NEED_W'(free_cnt_reg) >= need_reg);
        stat.take_done = !cur_used && (NEED_W'(k_inc) == need_reg);
    end

    always_comb
    begin
        map_next = map_reg;
        case (cmd.emit)
            RES_MARK:
            begin
                if (idx_ok)
                begin
                    map_next = map_reg | (BLOCK_TOTAL'(1) << idx_reg);
                end
            end
            RES_RUN:
            begin
                map_next = map_reg | run_mask;
            end
            RES_TAKE:
            begin
                map_next = map_reg | (BLOCK_TOTAL'(1) << scan_reg);
            end
            default:
            begin
                map_next = map_reg;
            end
        endcase
    end

    always_comb
    begin
        res_status = RS_ALLOC;
        res_number = '0;
        res_entry  = '0;
        res_count  = '0;
        res_last   = 1'b1;
        case (cmd.emit)
            RES_MARK:
            begin
                res_status = idx_ok ? RS_MARKED : RS_NOFIT;
                res_number = idx_reg;
            end
            RES_FAIL:
            begin
                res_status = RS_NOFIT;
                res_count  = count_sat;
            end
            RES_RUN:
            begin
                res_number = 5'(start_reg);
                res_count  = count_sat;
            end
            RES_TAKE:
            begin
                res_number = 5'(scan_reg);
                res_entry  = 5'(k_reg);
                res_count  = count_sat;
                res_last   = stat.take_done;
            end
            default:
            begin
                res_status = RS_ALLOC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BLOCK_BYTES_RESET;
            map_reg         <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_bytes_reg <= cfg_wdata;
            end
            map_reg    <= map_next;
            strobe_reg <= (cmd.emit != RES_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            indexed_reg   <= (command == CMD_INDEXED);
            size_zero_reg <= (file_size == '0);
            idx_reg       <= block_index;
            quot_reg      <= file_size;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            quot_reg    <= {quot_reg[SIZE_W-2:0], trial_ge};
            rem_reg     <= trial_ge ? BYTES_W'(trial - {1'b0, block_bytes_reg})
                                    : trial[BYTES_W-1:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.calc)
        begin
            if (size_zero_reg)
            begin
                need_reg <= '0;
            end
            else if (block_bytes_reg == '0)
            begin
                need_reg <= '1;
            end
            else
            begin
                // round up when a remainder is left
                need_reg <= {1'b0, quot_reg} + NEED_W'(rem_reg != '0);
            end
        end
        if (cmd.scan_init)
        begin
            scan_reg     <= '0;
            run_reg      <= '0;
            start_reg    <= '0;
            free_cnt_reg <= '0;
            k_reg        <= '0;
        end
        if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.run_step)
        begin
            run_reg <= cur_used ? '0 : run_inc;
            if (!cur_used && run_reg == '0)
            begin
                start_reg <= scan_reg;
            end
        end
        if (cmd.cnt_step && !cur_used)
        begin
            free_cnt_reg <= free_cnt_reg + 1'b1;
        end
        if (cmd.emit == RES_TAKE)
        begin
            k_reg <= k_inc;
        end
        if (cmd.emit != RES_NONE)
        begin
            status_reg <= res_status;
            number_reg <= res_number;
            entry_reg  <= res_entry;
            count_reg  <= res_count;
            last_reg   <= res_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign block_number  = number_reg;
    assign entry_index   = entry_reg;
    assign block_count   = count_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/disk_block_allocator_unit.sv =====
`default_nettype none
// allocate time is set by the divider and the one-block-per-cycle bitmap scans:
//   one scan for contiguous allocation, two scans for indexed allocation
// throughput: one item at a time, busy high until its last result beat is issued
// reset: asynchronous, clears the bitmap and loads block_bytes with 50
// results come out for one cycle each on result_strobe; there is no stall
// ----------------------------------------------------------------------------
// disk_block_allocator_unit: bitmap block allocator
// contiguous first-fit and indexed allocation, and block marking, over a used/free block bitmap
// ----------------------------------------------------------------------------
module disk_block_allocator_unit #(
    parameter int BLOCK_TOTAL = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] file_size,
    input  wire logic [4:0]  block_index,
    output      logic        result_strobe,
    output      logic [1:0]  status,
    output      logic [4:0]  block_number,
    output      logic [4:0]  entry_index,
    output      logic [5:0]  block_count,
    output      logic        last
);
    import dba_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    dba_datapath #(
        .BLOCK_TOTAL (BLOCK_TOTAL)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .command       (command),
        .file_size     (file_size),
        .block_index   (block_index),
        .cmd           (cmd),
        .stat          (stat),
        .result_strobe (result_strobe),
        .status        (status),
        .block_number  (block_number),
        .entry_index   (entry_index),
        .block_count   (block_count),
        .last          (last)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/dba_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dba_checker: port-level checks for the block allocator
// bound to the top level
// ----------------------------------------------------------------------------
module dba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  command,
    input wire logic        result_strobe,
    input wire logic [1:0]  status,
    input wire logic [4:0]  entry_index,
    input wire logic [5:0]  block_count,
    input wire logic        last
);
    import dba_pkg::*;

    // an accepted real command keeps the unit busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy
        && (command == CMD_CONTIG || command == CMD_INDEXED || command == CMD_MARK)
        |=> busy)
        else $error("accepted command did not raise busy");

    // more beats pending means the unit is still working
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("non-final beat while idle");

    // only indexed successes span several beats
    a_multi_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> (status == RS_ALLOC) && (block_count != 6'd0))
        else $error("non-final beat is not an indexed allocation");

    a_nofit_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (status == RS_NOFIT) |-> last && (entry_index == 5'd0))
        else $error("failure beat not final");

    a_marked: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (status == RS_MARKED) |-> last && (block_count == 6'd0))
        else $error("mark beat malformed");

endmodule

bind disk_block_allocator_unit dba_checker u_dba_checker (.*);
`default_nettype wire
